// ===== design/drs_pkg.sv =====
package drs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int BLOCK_BITS_DEF  = 16;
  localparam int TAG_W           = 8;
  localparam int NB_W            = 17;
  localparam int POL_W           = 2;
  localparam int ST_W            = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int SEEK_W          = 32;

  localparam logic [POL_W-1:0] POL_FCFS  = 2'd0;
  localparam logic [POL_W-1:0] POL_SSTF  = 2'd1;
  localparam logic [POL_W-1:0] POL_CSCAN = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b1;

  localparam logic [POL_W-1:0] POLICY_RST     = POL_CSCAN;
  localparam logic [NB_W-1:0]  NUM_BLOCKS_RST = 17'h10000;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_RANGE,
    CMD_DONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              write;
    logic [TAG_W-1:0]  tag;
  } cmd_ctl_t;

  typedef struct packed {
    logic              done_valid;
    logic [TAG_W-1:0]  done_tag;
    logic              issue_valid;
    logic              issue_write;
    logic [TAG_W-1:0]  issue_tag;
    logic [ST_W-1:0]   status;
  } res_ctl_t;

endpackage

// ===== design/drs_ram.sv =====
module drs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/drs_front.sv =====
module drs_front import drs_pkg::*; #(
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [BLOCK_BITS-1:0] in_req_block,
  input  logic                  in_req_write,
  input  logic [TAG_W-1:0]      in_req_tag,
  input  logic [NB_W-1:0]       num_blocks,
  output logic                  cmd_valid,
  output cmd_ctl_t              cmd_ctl,
  output logic [BLOCK_BITS-1:0] cmd_block,
  input  logic                  cmd_pop
);

  localparam int CMPW = (BLOCK_BITS > NB_W) ? BLOCK_BITS : NB_W;

  cmd_ctl_t              q_ctl_r [2];
  logic [BLOCK_BITS-1:0] q_blk_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            cnt_r;
  logic [1:0]            cnt_nxt;
  logic                  push;
  logic                  in_range;
  cmd_ctl_t              cls;

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_ctl   = q_ctl_r[rd_ptr_r];
  assign cmd_block = q_blk_r[rd_ptr_r];

  // range check against the disk size, done once on the way in
  assign in_range = CMPW'(in_req_block) < CMPW'(num_blocks);

  always_comb begin
    cls.write = in_req_write;
    cls.tag   = in_req_tag;
    if (in_mode) begin
      cls.kind = CMD_DONE;
    end else if (in_range) begin
      cls.kind = CMD_ENQ;
    end else begin
      cls.kind = CMD_RANGE;
    end
  end

  assign cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl_r[wr_ptr_r] <= cls;
      q_blk_r[wr_ptr_r] <= in_req_block;
    end
  end

endmodule

// ===== design/drs_back.sv =====
module drs_back import drs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  cmd_ctl_t              cmd_ctl,
  input  logic [BLOCK_BITS-1:0] cmd_block,
  output logic                  cmd_pop,
  input  logic [POL_W-1:0]      policy,
  input  logic [NB_W-1:0]       num_blocks,
  output logic                  out_valid,
  output res_ctl_t              res,
  output logic [BLOCK_BITS-1:0] res_block,
  output logic [SEEK_W-1:0]     seek_total
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW   = BLOCK_BITS + 1 + TAG_W;
  localparam int CMPW = (BLOCK_BITS > NB_W) ? BLOCK_BITS : NB_W;
  localparam int SUMW = ((CMPW > SEEK_W) ? CMPW : SEEK_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_COST,
    S_ACC,
    S_MOVE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic                  dbusy_r, dbusy_nxt;
  logic [BLOCK_BITS-1:0] flight_blk_r, flight_blk_nxt;
  logic [TAG_W-1:0]      flight_tag_r, flight_tag_nxt;
  logic [BLOCK_BITS-1:0] head_r, head_nxt;
  logic [SEEK_W-1:0]     acc_r, acc_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         best_idx_r, best_idx_nxt;
  logic [BLOCK_BITS-1:0] best_blk_r, best_blk_nxt;
  logic                  best_wr_r, best_wr_nxt;
  logic [TAG_W-1:0]      best_tag_r, best_tag_nxt;
  logic [BLOCK_BITS-1:0] best_dist_r, best_dist_nxt;
  logic                  best_above_r, best_above_nxt;
  logic [CMPW-1:0]       cost_r, cost_nxt;
  res_ctl_t              res_r, res_nxt;
  logic [BLOCK_BITS-1:0] res_blk_r, res_blk_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;

  logic [BLOCK_BITS-1:0] rd_blk;
  logic                  rd_wr;
  logic [TAG_W-1:0]      rd_tag;
  logic [BLOCK_BITS-1:0] rd_dist;
  logic                  rd_above;
  logic                  better;
  logic [CMPW:0]         wrap_base;
  logic [CMPW:0]         head_ext;
  logic [CMPW-1:0]       cost_calc;
  logic [SUMW-1:0]       acc_sum;
  logic [CNTW-1:0]       next_idx;
  logic [CNTW-1:0]       skip_idx;

  drs_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_blk   = ram_rdata[EW-1 -: BLOCK_BITS];
  assign rd_wr    = ram_rdata[TAG_W];
  assign rd_tag   = ram_rdata[TAG_W-1:0];
  assign rd_above = (rd_blk >= head_r);
  assign rd_dist  = rd_above ? (rd_blk - head_r) : (head_r - rd_blk);

  // candidate beats the best so far; strict compares keep the oldest on ties
  always_comb begin
    priority case (policy)
      POL_FCFS: better = 1'b0;
      POL_SSTF: better = (rd_dist < best_dist_r);
      default:  better = (rd_above && !best_above_r) ||
                         ((rd_above == best_above_r) && (rd_blk < best_blk_r));
    endcase
  end

  // wrap-around cost for circular scan, floored at zero
  assign wrap_base = (CMPW+1)'(num_blocks) + (CMPW+1)'(best_blk_r);
  assign head_ext  = (CMPW+1)'(head_r);

  always_comb begin
    priority case (policy)
      POL_FCFS, POL_SSTF: cost_calc = CMPW'(best_dist_r);
      default: begin
        if (best_above_r) begin
          cost_calc = CMPW'(best_dist_r);
        end else if (wrap_base >= head_ext) begin
          cost_calc = CMPW'(wrap_base - head_ext);
        end else begin
          cost_calc = '0;
        end
      end
    endcase
  end

  assign acc_sum  = SUMW'(acc_r) + SUMW'(cost_r);
  assign next_idx = CNTW'(best_idx_r) + CNTW'(1);
  assign skip_idx = CNTW'(idx_r) + CNTW'(2);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dbusy_nxt      = dbusy_r;
    flight_blk_nxt = flight_blk_r;
    flight_tag_nxt = flight_tag_r;
    head_nxt       = head_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    best_idx_nxt   = best_idx_r;
    best_blk_nxt   = best_blk_r;
    best_wr_nxt    = best_wr_r;
    best_tag_nxt   = best_tag_r;
    best_dist_nxt  = best_dist_r;
    best_above_nxt = best_above_r;
    cost_nxt       = cost_r;
    res_nxt        = res_r;
    res_blk_nxt    = res_blk_r;
    out_valid_nxt  = 1'b0;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = {cmd_block, cmd_ctl.write, cmd_ctl.tag};
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          res_nxt     = '0;
          res_blk_nxt = '0;
          case (cmd_ctl.kind)
            CMD_ENQ: begin
              if (count_r == CNTW'(QUEUE_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNTW'(1);
              end
            end
            CMD_RANGE: res_nxt.status = ST_RANGE;
            CMD_DONE: begin
              if (dbusy_r) begin
                res_nxt.done_valid = 1'b1;
                res_nxt.done_tag   = flight_tag_r;
                head_nxt           = flight_blk_r;
                dbusy_nxt          = 1'b0;
              end
            end
            default: res_nxt.status = ST_OK;
          endcase
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!dbusy_r && (count_r != '0)) begin
          ram_raddr = '0;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        // data for entry idx_r arrives while the next one is read
        ram_raddr = idx_r + AW'(1);
        if ((idx_r == '0) || better) begin
          best_idx_nxt   = idx_r;
          best_blk_nxt   = rd_blk;
          best_wr_nxt    = rd_wr;
          best_tag_nxt   = rd_tag;
          best_dist_nxt  = rd_dist;
          best_above_nxt = rd_above;
        end
        if (CNTW'(idx_r) == count_r - CNTW'(1)) begin
          state_nxt = S_COST;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_COST: begin
        cost_nxt  = cost_calc;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (acc_sum >= SUMW'({SEEK_W{1'b1}})) begin
          acc_nxt = '1;
        end else begin
          acc_nxt = acc_sum[SEEK_W-1:0];
        end
        res_nxt.issue_valid = 1'b1;
        res_nxt.issue_write = best_wr_r;
        res_nxt.issue_tag   = best_tag_r;
        res_blk_nxt         = best_blk_r;
        flight_blk_nxt      = best_blk_r;
        flight_tag_nxt      = best_tag_r;
        dbusy_nxt           = 1'b1;
        if (next_idx < count_r) begin
          ram_raddr = AW'(next_idx);
          idx_nxt   = best_idx_r;
          state_nxt = S_MOVE;
        end else begin
          count_nxt     = count_r - CNTW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MOVE: begin
        // close the gap: entry idx_r+1 moves down to idx_r
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (skip_idx >= count_r) begin
          count_nxt     = count_r - CNTW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ram_raddr = AW'(skip_idx);
          idx_nxt   = idx_r + AW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      dbusy_r      <= 1'b0;
      flight_blk_r <= '0;
      flight_tag_r <= '0;
      head_r       <= '0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dbusy_r      <= dbusy_nxt;
      flight_blk_r <= flight_blk_nxt;
      flight_tag_r <= flight_tag_nxt;
      head_r       <= head_nxt;
      acc_r        <= acc_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      best_idx_r   <= best_idx_nxt;
      best_blk_r   <= best_blk_nxt;
      best_wr_r    <= best_wr_nxt;
      best_tag_r   <= best_tag_nxt;
      best_dist_r  <= best_dist_nxt;
      best_above_r <= best_above_nxt;
      cost_r       <= cost_nxt;
      res_r        <= res_nxt;
      res_blk_r    <= res_blk_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign res        = res_r;
  assign res_block  = res_blk_r;
  assign seek_total = acc_r;

endmodule

// ===== design/disk_request_scheduler.sv =====
// disk request scheduler
// input channel: a command is taken at a clock edge with start high and busy low.
// in_mode 0 enqueues a request (in_req_block, in_req_write, in_req_tag), in_mode 1
// reports that the request in flight has finished. a two-entry command queue sits
// between the intake and the scheduler, so busy only rises when both slots are taken.
// result channel: every command gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot hold it off. out_status reports range or
// table-full rejection, out_done_* the completed request and out_issue_* the request
// sent to the disk, with the running seek total on out_seek_total.
// sequencing: a command that issues nothing is answered straight from the decide step;
// one that issues first scans the pending table (one entry per cycle from its memory's
// single read port), then computes and accumulates the seek cost, and then closes the
// gap behind the issued entry by moving each later entry down one slot.
// reset: table empty, disk idle, head at block 0, seek total zero, policy circular scan,
// disk size 65536 blocks. the user must write configuration through cfg_we/cfg_index/
// cfg_data only while no command is outstanding; the block itself does not enforce this.
module disk_request_scheduler import drs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [BLOCK_BITS-1:0] in_req_block,
  input  logic                  in_req_write,
  input  logic [TAG_W-1:0]      in_req_tag,
  output logic                  out_valid,
  output logic                  out_done_valid,
  output logic [TAG_W-1:0]      out_done_tag,
  output logic                  out_issue_valid,
  output logic [BLOCK_BITS-1:0] out_issue_block,
  output logic                  out_issue_write,
  output logic [TAG_W-1:0]      out_issue_tag,
  output logic [ST_W-1:0]       out_status,
  output logic [SEEK_W-1:0]     out_seek_total,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [NB_W-1:0]       cfg_data
);

  logic [POL_W-1:0]      policy_r;
  logic [NB_W-1:0]       num_blocks_r;
  logic                  cmd_valid;
  cmd_ctl_t              cmd_ctl;
  logic [BLOCK_BITS-1:0] cmd_block;
  logic                  cmd_pop;
  res_ctl_t              res;
  logic [BLOCK_BITS-1:0] res_block;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POLICY_RST;
      num_blocks_r <= NUM_BLOCKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY:     policy_r     <= cfg_data[POL_W-1:0];
        CFG_NUM_BLOCKS: num_blocks_r <= cfg_data;
      endcase
    end
  end

  drs_front #(
    .BLOCK_BITS (BLOCK_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_req_block (in_req_block),
    .in_req_write (in_req_write),
    .in_req_tag   (in_req_tag),
    .num_blocks   (num_blocks_r),
    .cmd_valid    (cmd_valid),
    .cmd_ctl      (cmd_ctl),
    .cmd_block    (cmd_block),
    .cmd_pop      (cmd_pop)
  );

  drs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ctl    (cmd_ctl),
    .cmd_block  (cmd_block),
    .cmd_pop    (cmd_pop),
    .policy     (policy_r),
    .num_blocks (num_blocks_r),
    .out_valid  (out_valid),
    .res        (res),
    .res_block  (res_block),
    .seek_total (out_seek_total)
  );

  assign out_done_valid  = res.done_valid;
  assign out_done_tag    = res.done_tag;
  assign out_issue_valid = res.issue_valid;
  assign out_issue_block = res_block;
  assign out_issue_write = res.issue_write;
  assign out_issue_tag   = res.issue_tag;
  assign out_status      = res.status;

  // results never come back to back
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe on consecutive cycles");

  // the seek total only grows, it saturates rather than wraps
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_seek_total >= $past(out_seek_total))
    else $error("seek total went down");

  // a full table means the disk is busy, so a full rejection neither completes nor issues
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (!out_issue_valid && !out_done_valid))
    else $error("issue or completion alongside a table-full rejection");

  // completions are never rejected
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_valid) |-> out_status == ST_OK)
    else $error("completion carries a rejection status");

endmodule
